// ===== hw/rtl/rlec_pkg.sv =====
// shared types and constants for the rgb led effect controller
// depends on nothing; every rtl file of the block refers to it by scoped names
`timescale 1ns / 1ps
`default_nettype none

package rlec_pkg;

	// stream payload widths
	localparam int OP_W      = 4;
	localparam int HUE_W     = 10;
	localparam int SAT_W     = 8;
	localparam int LIGHT_W   = 8;
	localparam int SAMPLE_W  = 10;
	localparam int CHAN_W    = 8;
	localparam int S_DATA_W  = 40;
	localparam int M_DATA_W  = 24;

	// configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 8;
	localparam int SPEED_W    = 5;
	localparam int CNT_W      = 8;

	localparam int QUEUE_DEPTH = 2;

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_HUE_SHIFT_INTERVAL = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_HUE_SHIFT_STEP     = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_FADE_INTERVAL      = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_FADE_STEP          = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_BRIGHT_STEP        = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_SPEED_MIN          = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_SPEED_MAX          = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_SPEED_DEFAULT      = 3'd7;

	// register reset values
	localparam logic [7:0]         RST_HUE_SHIFT_INTERVAL = 8'd15;
	localparam logic [7:0]         RST_HUE_SHIFT_STEP     = 8'd10;
	localparam logic [7:0]         RST_FADE_INTERVAL      = 8'd5;
	localparam logic [7:0]         RST_FADE_STEP          = 8'd13;
	localparam logic [7:0]         RST_BRIGHT_STEP        = 8'd26;
	localparam logic [SPEED_W-1:0] RST_SPEED_MIN          = 5'd5;
	localparam logic [SPEED_W-1:0] RST_SPEED_MAX          = 5'd20;
	localparam logic [SPEED_W-1:0] RST_SPEED_DEFAULT      = 5'd10;

	// opcodes on the input stream
	localparam logic [OP_W-1:0] OP_TICK   = 4'd0;
	localparam logic [OP_W-1:0] OP_COLOR  = 4'd1;
	localparam logic [OP_W-1:0] OP_OFF    = 4'd2;
	localparam logic [OP_W-1:0] OP_UP     = 4'd3;
	localparam logic [OP_W-1:0] OP_DOWN   = 4'd4;
	localparam logic [OP_W-1:0] OP_AUDIO  = 4'd5;
	localparam logic [OP_W-1:0] OP_STROBE = 4'd6;
	localparam logic [OP_W-1:0] OP_FLASH  = 4'd7;
	localparam logic [OP_W-1:0] OP_SMOOTH = 4'd8;
	localparam logic [OP_W-1:0] OP_FADE   = 4'd9;

	// hsv conversion constants
	localparam logic [10:0] SECTOR   = 11'd1024;
	localparam logic [13:0] TURN6    = 14'd6144;
	localparam logic [12:0] HALF6    = 13'd3072;
	localparam logic [17:0] MIX_FULL = 18'd261120;

	typedef enum logic [3:0] {
		CMD_TICK,
		CMD_COLOR,
		CMD_OFF,
		CMD_UP,
		CMD_DOWN,
		CMD_AUDIO,
		CMD_STROBE,
		CMD_FLASH,
		CMD_SMOOTH,
		CMD_FADE,
		CMD_NOP
	} cmd_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [HUE_W-1:0]    hue;
		logic [SAT_W-1:0]    sat;
		logic [LIGHT_W-1:0]  light;
		logic [SAMPLE_W-1:0] sample;
	} entry_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic   valid;
		entry_t head;
	} q_head_t;

	typedef enum logic [1:0] {
		ST_WAIT,
		ST_CONV,
		ST_OUT
	} back_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rlec_front.sv =====
// front end: takes input items and classifies the opcode into a command
// depends on rlec_pkg
`timescale 1ns / 1ps
`default_nettype none

module rlec_front (
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [rlec_pkg::S_DATA_W-1:0]    s_tdata,
	input  wire logic [rlec_pkg::OP_W-1:0]        s_tuser,
	input  wire logic                             q_full,
	output logic                                  push,
	output rlec_pkg::entry_t                      push_entry
);

	rlec_pkg::cmd_t cmd;

	always_comb begin
		case (s_tuser)
			rlec_pkg::OP_TICK:   cmd = rlec_pkg::CMD_TICK;
			rlec_pkg::OP_COLOR:  cmd = rlec_pkg::CMD_COLOR;
			rlec_pkg::OP_OFF:    cmd = rlec_pkg::CMD_OFF;
			rlec_pkg::OP_UP:     cmd = rlec_pkg::CMD_UP;
			rlec_pkg::OP_DOWN:   cmd = rlec_pkg::CMD_DOWN;
			rlec_pkg::OP_AUDIO:  cmd = rlec_pkg::CMD_AUDIO;
			rlec_pkg::OP_STROBE: cmd = rlec_pkg::CMD_STROBE;
			rlec_pkg::OP_FLASH:  cmd = rlec_pkg::CMD_FLASH;
			rlec_pkg::OP_SMOOTH: cmd = rlec_pkg::CMD_SMOOTH;
			rlec_pkg::OP_FADE:   cmd = rlec_pkg::CMD_FADE;
			default:             cmd = rlec_pkg::CMD_NOP;
		endcase
	end

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	assign push_entry.cmd    = cmd;
	assign push_entry.hue    = s_tdata[9:0];
	assign push_entry.sat    = s_tdata[17:10];
	assign push_entry.light  = s_tdata[25:18];
	assign push_entry.sample = s_tdata[35:26];

endmodule

`default_nettype wire

// ===== hw/rtl/rlec_queue.sv =====
// command queue between front and back end
// depends on rlec_pkg
`timescale 1ns / 1ps
`default_nettype none

module rlec_queue #(
	parameter int DEPTH = rlec_pkg::QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire rlec_pkg::entry_t  push_entry,
	output logic                   full,
	input  wire logic              pop,
	output rlec_pkg::q_head_t      head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rlec_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full       = (count_q == CW'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rlec_back.sv =====
// back end: effect state, tick timers, key commands and hsv to rgb pipeline
// depends on rlec_pkg; fed by rlec_queue
`timescale 1ns / 1ps
`default_nettype none

module rlec_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire rlec_pkg::q_head_t                 head,
	output logic                                   pop,
	input  wire logic                              cfg_we,
	input  wire logic [rlec_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  wire logic [rlec_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [rlec_pkg::M_DATA_W-1:0]          m_tdata
);

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;
	localparam logic [1:0] CH_DONE  = 2'd3;

	// configuration
	logic [7:0] hs_int_q, hs_step_q, fd_int_q, fd_step_q, br_step_q;
	logic [rlec_pkg::SPEED_W-1:0] sp_min_q, sp_max_q, sp_def_q;

	// effect state
	logic [9:0] hue_q, hue_n;
	logic [7:0] sat_q, sat_n, bright_q, bright_n;
	logic [rlec_pkg::SPEED_W-1:0] speed_q, speed_n;
	logic audio_q, audio_n, flash_q, flash_n, strobe_q, strobe_n;
	logic fade_q, fade_n, smooth_q, smooth_n, phase_q, phase_n, rising_q, rising_n;
	logic [rlec_pkg::CNT_W-1:0] shift_cnt_q, shift_cnt_n, eff_cnt_q, eff_cnt_n;
	logic [rlec_pkg::CNT_W-1:0] fade_cnt_q, fade_cnt_n;

	rlec_pkg::back_state_t state_q, state_n;
	logic apply;

	// helpers on the current state
	logic [10:0] hue_sum;
	logic [8:0]  fade_sum, br_sum;
	logic [7:0]  fade_dec, br_dec;
	logic [17:0] audio_prod;
	logic [5:0]  speed_up;
	logic [4:0]  speed_dn;
	logic        fx, fd;

	assign hue_sum    = {1'b0, hue_q} + {3'b0, hs_step_q};
	assign fade_sum   = {1'b0, bright_q} + {1'b0, fd_step_q};
	assign fade_dec   = (bright_q > fd_step_q) ? bright_q - fd_step_q : 8'd0;
	assign br_sum     = {1'b0, bright_q} + {1'b0, br_step_q};
	assign br_dec     = (bright_q > br_step_q) ? bright_q - br_step_q : 8'd0;
	assign audio_prod = {head.head.sample, 8'd0} - {8'd0, head.head.sample};
	assign speed_up   = {1'b0, speed_q} + 6'd1;
	assign speed_dn   = speed_q - 5'd1;
	assign fx         = !audio_q && (strobe_q || flash_q);
	assign fd         = !audio_q && !fx && fade_q;

	always_comb begin
		hue_n       = hue_q;
		sat_n       = sat_q;
		bright_n    = bright_q;
		speed_n     = speed_q;
		audio_n     = audio_q;
		flash_n     = flash_q;
		strobe_n    = strobe_q;
		fade_n      = fade_q;
		smooth_n    = smooth_q;
		phase_n     = phase_q;
		rising_n    = rising_q;
		shift_cnt_n = shift_cnt_q;
		eff_cnt_n   = eff_cnt_q;
		fade_cnt_n  = fade_cnt_q;
		case (head.head.cmd)
			rlec_pkg::CMD_TICK: begin
				if (smooth_q && shift_cnt_q >= hs_int_q) begin
					shift_cnt_n = '0;
					hue_n = (hue_sum >= rlec_pkg::SECTOR) ? 10'd0 : hue_sum[9:0];
				end else if (shift_cnt_q != '1) begin
					shift_cnt_n = shift_cnt_q + 1'b1;
				end
				if (fx && eff_cnt_q >= {3'b0, speed_q}) begin
					eff_cnt_n = '0;
					phase_n = !phase_q;
					if (strobe_q) begin
						hue_n = 10'd0 - hue_n;
					end else begin
						bright_n = phase_n ? 8'd0 : 8'hff;
					end
				end else if (eff_cnt_q != '1) begin
					eff_cnt_n = eff_cnt_q + 1'b1;
				end
				if (fd && fade_cnt_q >= fd_int_q) begin
					fade_cnt_n = '0;
					if (rising_q) begin
						if (fade_sum >= 9'd255) begin
							bright_n = 8'hff;
							rising_n = 1'b0;
						end else begin
							bright_n = fade_sum[7:0];
						end
					end else begin
						bright_n = fade_dec;
						if (fade_dec == 8'd0) begin
							rising_n = 1'b1;
						end
					end
				end else if (fade_cnt_q != '1) begin
					fade_cnt_n = fade_cnt_q + 1'b1;
				end
				if (audio_q) begin
					bright_n = audio_prod[17:10];
				end
			end
			rlec_pkg::CMD_COLOR: begin
				hue_n    = head.head.hue;
				sat_n    = head.head.sat;
				bright_n = head.head.light;
			end
			rlec_pkg::CMD_OFF: begin
				hue_n    = '0;
				sat_n    = '0;
				bright_n = '0;
				speed_n  = sp_def_q;
				audio_n  = 1'b0;
				flash_n  = 1'b0;
				strobe_n = 1'b0;
				fade_n   = 1'b0;
				smooth_n = 1'b0;
			end
			rlec_pkg::CMD_UP: begin
				if (flash_q || strobe_q) begin
					speed_n = (speed_up > {1'b0, sp_max_q}) ? sp_max_q : speed_up[4:0];
				end else begin
					bright_n = br_sum[8] ? 8'hff : br_sum[7:0];
				end
			end
			rlec_pkg::CMD_DOWN: begin
				if (flash_q || strobe_q) begin
					// zero speed wraps below the minimum too
					speed_n = (speed_q == '0 || speed_dn < sp_min_q) ? sp_min_q : speed_dn;
				end else begin
					bright_n = br_dec;
				end
			end
			rlec_pkg::CMD_AUDIO: begin
				audio_n  = !audio_q;
				flash_n  = 1'b0;
				strobe_n = 1'b0;
				fade_n   = 1'b0;
			end
			rlec_pkg::CMD_STROBE: begin
				strobe_n = !strobe_q;
				audio_n  = 1'b0;
				flash_n  = 1'b0;
				fade_n   = 1'b0;
			end
			rlec_pkg::CMD_FLASH: begin
				flash_n  = !flash_q;
				audio_n  = 1'b0;
				strobe_n = 1'b0;
				fade_n   = 1'b0;
			end
			rlec_pkg::CMD_SMOOTH: smooth_n = !smooth_q;
			rlec_pkg::CMD_FADE: begin
				fade_n   = !fade_q;
				audio_n  = 1'b0;
				flash_n  = 1'b0;
				strobe_n = 1'b0;
			end
			default: ;
		endcase
	end

	// conversion pipeline: one channel issued per cycle
	logic [1:0]  ch_q;
	logic        issue;
	logic [13:0] x_raw;
	logic [12:0] x_mod;
	logic [12:0] x_dev;
	logic [11:0] c_raw;
	logic [10:0] c_val;
	logic [10:0] inv_c;
	logic [13:0] offset;
	logic        valid_s1, valid_s2;
	logic [1:0]  ch_s1, ch_s2;
	logic [18:0] prod_s1;
	logic [17:0] mixv;
	logic [25:0] bprod_s2;
	logic [15:0] quot_in;
	logic [16:0] quot_sum;
	logic [7:0]  chan_val;
	logic [7:0]  chan_q [3];
	logic        out_load;

	always_comb begin
		case (ch_q)
			CH_GREEN: offset = 14'd4096;
			CH_BLUE:  offset = 14'd2048;
			default:  offset = 14'd0;
		endcase
	end

	assign issue  = (state_q == rlec_pkg::ST_CONV) && (ch_q != CH_DONE);
	assign x_raw  = {1'b0, hue_q, 3'b0} - {3'b0, hue_q, 1'b0} + offset;
	assign x_mod  = (x_raw >= rlec_pkg::TURN6) ? 13'(x_raw - rlec_pkg::TURN6) : x_raw[12:0];
	assign x_dev  = (x_mod >= rlec_pkg::HALF6) ? x_mod - rlec_pkg::HALF6
						: rlec_pkg::HALF6 - x_mod;
	assign c_raw  = (x_dev > 13'(rlec_pkg::SECTOR)) ? 12'(x_dev - 13'(rlec_pkg::SECTOR)) : 12'd0;
	assign c_val  = (c_raw > 12'(rlec_pkg::SECTOR)) ? rlec_pkg::SECTOR : c_raw[10:0];
	assign inv_c  = rlec_pkg::SECTOR - c_val;
	assign mixv   = rlec_pkg::MIX_FULL - prod_s1[17:0];
	// divide by 1024*255: shift, then exact reciprocal form for /255
	assign quot_in  = bprod_s2[25:10];
	assign quot_sum = {1'b0, quot_in} + 17'd1 + {9'd0, quot_in[15:8]};
	assign chan_val = quot_sum[15:8];

	always_ff @(posedge clk) begin
		if (issue) begin
			prod_s1 <= inv_c * sat_q;
			ch_s1   <= ch_q;
		end
		if (valid_s1) begin
			bprod_s2 <= bright_q * mixv;
			ch_s2    <= ch_s1;
		end
		if (valid_s2) begin
			chan_q[ch_s2] <= chan_val;
		end
		if (out_load) begin
			m_tdata <= {chan_q[CH_BLUE], chan_q[CH_GREEN], chan_q[CH_RED]};
		end
	end

	always_comb begin
		state_n  = state_q;
		apply    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			rlec_pkg::ST_WAIT: begin
				if (head.valid) begin
					apply   = 1'b1;
					state_n = rlec_pkg::ST_CONV;
				end
			end
			rlec_pkg::ST_CONV: begin
				if (valid_s2 && ch_s2 == CH_BLUE) begin
					state_n = rlec_pkg::ST_OUT;
				end
			end
			rlec_pkg::ST_OUT: begin
				if (!m_tvalid || m_tready) begin
					out_load = 1'b1;
					state_n  = rlec_pkg::ST_WAIT;
				end
			end
			default: state_n = rlec_pkg::ST_WAIT;
		endcase
	end

	assign pop = apply;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rlec_pkg::ST_WAIT;
			ch_q     <= CH_RED;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			state_q  <= state_n;
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			if (apply) begin
				ch_q <= CH_RED;
			end else if (issue) begin
				ch_q <= ch_q + 1'b1;
			end
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_q       <= '0;
			sat_q       <= '0;
			bright_q    <= '0;
			speed_q     <= rlec_pkg::RST_SPEED_DEFAULT;
			audio_q     <= 1'b0;
			flash_q     <= 1'b0;
			strobe_q    <= 1'b0;
			fade_q      <= 1'b0;
			smooth_q    <= 1'b0;
			phase_q     <= 1'b0;
			rising_q    <= 1'b0;
			shift_cnt_q <= '0;
			eff_cnt_q   <= '0;
			fade_cnt_q  <= '0;
		end else if (apply) begin
			hue_q       <= hue_n;
			sat_q       <= sat_n;
			bright_q    <= bright_n;
			speed_q     <= speed_n;
			audio_q     <= audio_n;
			flash_q     <= flash_n;
			strobe_q    <= strobe_n;
			fade_q      <= fade_n;
			smooth_q    <= smooth_n;
			phase_q     <= phase_n;
			rising_q    <= rising_n;
			shift_cnt_q <= shift_cnt_n;
			eff_cnt_q   <= eff_cnt_n;
			fade_cnt_q  <= fade_cnt_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_int_q  <= rlec_pkg::RST_HUE_SHIFT_INTERVAL;
			hs_step_q <= rlec_pkg::RST_HUE_SHIFT_STEP;
			fd_int_q  <= rlec_pkg::RST_FADE_INTERVAL;
			fd_step_q <= rlec_pkg::RST_FADE_STEP;
			br_step_q <= rlec_pkg::RST_BRIGHT_STEP;
			sp_min_q  <= rlec_pkg::RST_SPEED_MIN;
			sp_max_q  <= rlec_pkg::RST_SPEED_MAX;
			sp_def_q  <= rlec_pkg::RST_SPEED_DEFAULT;
		end else if (cfg_we) begin
			case (cfg_addr)
				rlec_pkg::REG_HUE_SHIFT_INTERVAL: hs_int_q  <= cfg_wdata;
				rlec_pkg::REG_HUE_SHIFT_STEP:     hs_step_q <= cfg_wdata;
				rlec_pkg::REG_FADE_INTERVAL:      fd_int_q  <= cfg_wdata;
				rlec_pkg::REG_FADE_STEP:          fd_step_q <= cfg_wdata;
				rlec_pkg::REG_BRIGHT_STEP:        br_step_q <= cfg_wdata;
				rlec_pkg::REG_SPEED_MIN:          sp_min_q  <= cfg_wdata[4:0];
				rlec_pkg::REG_SPEED_MAX:          sp_max_q  <= cfg_wdata[4:0];
				rlec_pkg::REG_SPEED_DEFAULT:      sp_def_q  <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rgb_led_effect_controller.sv =====
// top level of the rgb led effect controller: front end, command queue, back end
// depends on rlec_pkg, rlec_front, rlec_queue, rlec_back
//
//  channel | direction | signals                        | carries
//  --------+-----------+--------------------------------+-------------------------------
//  s_*     | in        | s_tvalid s_tready s_tdata s_tuser | one event item (tick or key)
//  m_*     | out       | m_tvalid m_tready m_tdata      | one rgb item per event item
//  cfg_*   | in        | cfg_we cfg_addr cfg_wdata      | register writes, no read-back
//
// each item passes through the back end in order: the command is applied, the red, green
// and blue channels are issued into the two-multiplier conversion pipeline and drained
// from it, and the output register is loaded; only then does the back end take the next item
// the queue takes items, until it is full, while the back end works or the output stalls
// arst_n clears control state and loads the register defaults
`timescale 1ns / 1ps
`default_nettype none

module rgb_led_effect_controller #(
	parameter int QUEUE_DEPTH = rlec_pkg::QUEUE_DEPTH
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// hue_in[9:0], sat_in[17:10], light_in[25:18], audio_sample[35:26], zero pad
	input  wire logic [rlec_pkg::S_DATA_W-1:0]     s_tdata,
	// op[3:0]
	input  wire logic [rlec_pkg::OP_W-1:0]         s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// red[7:0], green[15:8], blue[23:16]
	output logic [rlec_pkg::M_DATA_W-1:0]          m_tdata,
	input  wire logic                              cfg_we,
	input  wire logic [rlec_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  wire logic [rlec_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	logic              q_full;
	logic              push;
	logic              pop;
	rlec_pkg::entry_t  push_entry;
	rlec_pkg::q_head_t head;

	rlec_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	rlec_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head       (head)
	);

	rlec_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/rlec_checker.sv =====
// port-level checks for the rgb led effect controller, bound to the top level
// depends on rlec_pkg and rgb_led_effect_controller
`timescale 1ns / 1ps
`default_nettype none

module rlec_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              s_tvalid,
	input wire logic                              s_tready,
	input wire logic                              m_tvalid,
	input wire logic                              m_tready,
	input wire logic [rlec_pkg::M_DATA_W-1:0]     m_tdata
);

	// items taken in but not yet delivered
	logic [7:0] pending_q;
	logic       in_acc, out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			case ({in_acc, out_acc})
				2'b10:   pending_q <= pending_q + 1'b1;
				2'b01:   pending_q <= pending_q - 1'b1;
				default: pending_q <= pending_q;
			endcase
		end
	end

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output item dropped while stalled");

	a_data_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output item changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 8'd0 |-> !m_tvalid)
		else $error("output item with no input item pending");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 8'd0 |-> s_tready)
		else $error("idle block refuses input");

endmodule

bind rgb_led_effect_controller rlec_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
